[hdl/batmon_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Battery monitor package
// Shared constants, register indexes and pipeline types of the battery
// monitor with averaging filter and LED indicator.
// ----------------------------------------------------------------------------
package batmon_pkg;

  localparam int unsigned SAMPLE_DIVIDE = 10;
  localparam int unsigned PHASE_W       = $clog2(SAMPLE_DIVIDE + 1);

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned LEVEL_W   = SAMPLE_W + FRAC_W;
  localparam int unsigned ACC_W     = LEVEL_W + 4;
  localparam int unsigned LEVEL_MAX = ((1 << SAMPLE_W) - 1) << FRAC_W;

  // divide by ten: multiply by ceil(2^25/10), exact for every value below 2^22
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + 9) / 10;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned GAIN_SHIFT = 24;
  localparam int unsigned PROD_W     = LEVEL_W + GAIN_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THRESHOLD  = 3'd0,
    REG_HALF_THRESHOLD = 3'd1,
    REG_CHECK_INTERVAL = 3'd2,
    REG_VERSION_DELAY  = 3'd3,
    REG_BLINK_PERIOD   = 3'd4,
    REG_VOLTAGE_GAIN   = 3'd5
  } cfg_idx_e;

  localparam logic [CNT_W-1:0]  RST_LOW_THRESHOLD  = 16'd650;
  localparam logic [CNT_W-1:0]  RST_HALF_THRESHOLD = 16'd700;
  localparam logic [CNT_W-1:0]  RST_CHECK_INTERVAL = 16'd1000;
  localparam logic [CNT_W-1:0]  RST_VERSION_DELAY  = 16'd500;
  localparam logic [CNT_W-1:0]  RST_BLINK_PERIOD   = 16'd350;
  localparam logic [GAIN_W-1:0] RST_VOLTAGE_GAIN   = 20'd64000;

  typedef struct packed {
    logic [CNT_W-1:0]  low_threshold;
    logic [CNT_W-1:0]  half_threshold;
    logic [CNT_W-1:0]  check_interval;
    logic [CNT_W-1:0]  version_delay;
    logic [CNT_W-1:0]  blink_period;
    logic [GAIN_W-1:0] voltage_gain;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               report;
    logic               pulse;
  } mid_t;

  typedef struct packed {
    logic               led;
    logic               report;
    logic [VALUE_W-1:0] value;
    logic               pulse;
  } res_t;

endpackage
`default_nettype wire

[hdl/battery_monitor_led_indicator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Battery monitor with LED indicator
// Three-register pipeline: sample register, filter/timing stage, indicator
// stage with result register.
// ----------------------------------------------------------------------------
// Each transaction on the input is one millisecond tick with a converter
// sample and gives exactly one result transaction. One tick is accepted
// every cycle while in_stall_o is low: the first stage holds the
// divide-by-ten reciprocal multiply of the average and the check counters,
// the second the gain multiply, threshold compares and LED blink logic;
// each stage keeps its own state. The user writes registers through the
// configuration port while no transaction is in flight; it is not enforced.
module battery_monitor_led_indicator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [batmon_pkg::SAMPLE_W-1:0]    adc_sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    led_on_o,
  output logic                                    report_valid_o,
  output logic [batmon_pkg::VALUE_W-1:0]          battery_value_o,
  output logic                                    send_version_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [batmon_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [batmon_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  batmon_pkg::cfg_t cfg_q;
  logic             in_valid_q, mid_valid_q, out_valid_q;
  logic [batmon_pkg::SAMPLE_W-1:0] sample_q;
  batmon_pkg::mid_t mid_d, mid_q;
  batmon_pkg::res_t res_d, res_q;
  logic             out_load, mid_move, mid_load, in_move, in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold  <= batmon_pkg::RST_LOW_THRESHOLD;
      cfg_q.half_threshold <= batmon_pkg::RST_HALF_THRESHOLD;
      cfg_q.check_interval <= batmon_pkg::RST_CHECK_INTERVAL;
      cfg_q.version_delay  <= batmon_pkg::RST_VERSION_DELAY;
      cfg_q.blink_period   <= batmon_pkg::RST_BLINK_PERIOD;
      cfg_q.voltage_gain   <= batmon_pkg::RST_VOLTAGE_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        batmon_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= cfg_wdata_i[15:0];
        batmon_pkg::REG_HALF_THRESHOLD: cfg_q.half_threshold <= cfg_wdata_i[15:0];
        batmon_pkg::REG_CHECK_INTERVAL: cfg_q.check_interval <= cfg_wdata_i[15:0];
        batmon_pkg::REG_VERSION_DELAY:  cfg_q.version_delay  <= cfg_wdata_i[15:0];
        batmon_pkg::REG_BLINK_PERIOD:   cfg_q.blink_period   <= cfg_wdata_i[15:0];
        batmon_pkg::REG_VOLTAGE_GAIN:   cfg_q.voltage_gain   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign out_load   = !out_valid_q || !out_stall_i;
  assign mid_move   = mid_valid_q && out_load;
  assign mid_load   = !mid_valid_q || mid_move;
  assign in_move    = in_valid_q && mid_load;
  assign in_load    = !in_valid_q || in_move;
  assign in_stall_o = !in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load)  in_valid_q  <= in_valid_i;
      if (mid_load) mid_valid_q <= in_valid_q;
      if (out_load) out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) sample_q <= adc_sample_i;
    if (in_move)               mid_q    <= mid_d;
    if (mid_move)              res_q    <= res_d;
  end

  batmon_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (in_move),
    .sample_i (sample_q),
    .cfg_i    (cfg_q),
    .mid_o    (mid_d)
  );

  batmon_indicator u_indicator (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mid_move),
    .mid_i  (mid_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_valid_o     = out_valid_q;
  assign led_on_o        = res_q.led;
  assign report_valid_o  = res_q.report;
  assign battery_value_o = res_q.value;
  assign send_version_o  = res_q.pulse;

  a_value_only_on_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.report |-> res_q.value == '0)
    else $error("battery value set without a report");

  a_pulse_not_on_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid_q |-> !(mid_q.report && mid_q.pulse))
    else $error("version pulse on a check tick");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid_q |-> mid_q.level <= batmon_pkg::LEVEL_W'(batmon_pkg::LEVEL_MAX))
    else $error("filtered level out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && mid_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken while pipeline is full and stalled");

endmodule
`default_nettype wire

[hdl/batmon_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Battery monitor filter and check timing
// Averages every tenth sample into the level and times the battery checks
// and version pulses.
// ----------------------------------------------------------------------------
module batmon_filter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic [batmon_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire batmon_pkg::cfg_t                 cfg_i,
  output batmon_pkg::mid_t                      mid_o
);

  localparam int unsigned AW = batmon_pkg::ACC_W;
  localparam int unsigned LW = batmon_pkg::LEVEL_W;
  localparam int unsigned PW = batmon_pkg::PHASE_W;
  localparam int unsigned CW = batmon_pkg::CNT_W;

  logic [LW-1:0]   level_q, level_d;
  logic [PW-1:0]   phase_q, phase_d;
  logic [CW-1:0]   check_elapsed_q, check_elapsed_d;
  logic            version_sent_q, version_sent_d;
  logic [AW-1:0]   acc;
  logic [2*AW-1:0] quot_prod;
  logic [CW-1:0]   elapsed;
  logic            check;
  logic            pulse;

  always_comb begin
    acc = AW'({level_q, 3'b000}) + AW'(level_q)
        + AW'({sample_i, {batmon_pkg::FRAC_W{1'b0}}});
    quot_prod = (2*AW)'(acc) * (2*AW)'(batmon_pkg::RECIP);
    level_d = (phase_q == '0) ? quot_prod[batmon_pkg::RECIP_SHIFT +: LW] : level_q;
    phase_d = (phase_q == PW'(batmon_pkg::SAMPLE_DIVIDE - 1)) ? '0 : phase_q + 1'b1;

    elapsed = (check_elapsed_q == '1) ? '1 : check_elapsed_q + 1'b1;
    check   = (elapsed >= cfg_i.check_interval);
    pulse   = !check && (elapsed >= cfg_i.version_delay) && !version_sent_q;
    check_elapsed_d = check ? '0 : elapsed;
    version_sent_d  = check ? 1'b0 : (version_sent_q || pulse);

    mid_o.level  = level_d;
    mid_o.report = check;
    mid_o.pulse  = pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q         <= '0;
      phase_q         <= '0;
      check_elapsed_q <= '0;
      version_sent_q  <= 1'b0;
    end else if (en_i) begin
      level_q         <= level_d;
      phase_q         <= phase_d;
      check_elapsed_q <= check_elapsed_d;
      version_sent_q  <= version_sent_d;
    end
  end

endmodule
`default_nettype wire

[hdl/batmon_indicator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Battery monitor indicator
// Scales the level to centivolts and drives the LED in dark, lit or blink
// mode.
// ----------------------------------------------------------------------------
module batmon_indicator (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire batmon_pkg::mid_t  mid_i,
  input  wire batmon_pkg::cfg_t  cfg_i,
  output batmon_pkg::res_t       res_o
);

  localparam int unsigned PW = batmon_pkg::PROD_W;
  localparam int unsigned CW = batmon_pkg::CNT_W;
  localparam int unsigned VW = batmon_pkg::VALUE_W;

  logic          blinking_q, blinking_d;
  logic          led_q, led_d;
  logic [CW-1:0] blink_elapsed_q, blink_elapsed_d;
  logic [PW-1:0] prod;
  logic [VW-1:0] value;
  logic [CW-1:0] blink_next;

  always_comb begin
    prod  = PW'(mid_i.level) * PW'(cfg_i.voltage_gain);
    value = VW'(prod[PW-1:batmon_pkg::GAIN_SHIFT]);

    blinking_d      = blinking_q;
    led_d           = led_q;
    blink_elapsed_d = blink_elapsed_q;
    blink_next      = (blink_elapsed_q == '1) ? '1 : blink_elapsed_q + 1'b1;

    if (blinking_q) begin
      if (blink_next >= cfg_i.blink_period) begin
        led_d           = !led_q;
        blink_elapsed_d = '0;
      end else begin
        blink_elapsed_d = blink_next;
      end
    end

    if (mid_i.report) begin
      if (value <= cfg_i.low_threshold) begin
        blinking_d      = 1'b1;
        led_d           = 1'b1;
        blink_elapsed_d = '0;
      end else begin
        blinking_d = 1'b0;
        led_d      = (value <= cfg_i.half_threshold);
      end
    end

    res_o.led    = led_d;
    res_o.report = mid_i.report;
    res_o.value  = mid_i.report ? value : '0;
    res_o.pulse  = mid_i.pulse;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blinking_q      <= 1'b0;
      led_q           <= 1'b0;
      blink_elapsed_q <= '0;
    end else if (en_i) begin
      blinking_q      <= blinking_d;
      led_q           <= led_d;
      blink_elapsed_q <= blink_elapsed_d;
    end
  end

endmodule
`default_nettype wire
